// ===== hw/rtl/ilid_pkg.sv =====
// shared types, codes and widths for the indexed list block
`timescale 1ns / 1ps

package ilid_pkg;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 6;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int ECOUNT_W    = 7;
    localparam int DEPTH_DFLT  = 64;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEAD   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TAIL   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/ilid_cell.sv =====
// one storage cell of the list chain, shifts towards or away from its neighbours
`timescale 1ns / 1ps

module ilid_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                       i_clk,
    input  ilid_pkg::t_cell_ctl        i_ctl,
    input  logic [CW-1:0]              i_pos,
    input  logic [ilid_pkg::DATA_W-1:0] i_value,
    input  logic [ilid_pkg::DATA_W-1:0] i_left,
    input  logic [ilid_pkg::DATA_W-1:0] i_right,
    output logic [ilid_pkg::DATA_W-1:0] o_value
);
    import ilid_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                n_value = i_left;
            end else if (MY_IDX == i_pos) begin
                n_value = i_value;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// Ordered list of up to DEPTH signed words held in a shifting chain of cells.
// Input channel (i_in_valid / o_in_ready) carries one word: i_func, i_position,
// i_item_value. Functions: get, insert at position, insert at head, append at
// tail, delete at position. Output channel (o_out_valid / i_out_ready) returns
// one word per input: o_read_value, o_status, o_entry_count (count after the op).
// The result is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle unless stalled; all cells at or past the
// position shift or load in the same cycle, so the next word sees the new list.
// The get path is a DEPTH-wide select over the cell outputs.
// A word is accepted while the output register is empty or being taken, so a
// stalled receiver holds the result and back-pressures the input after one word.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared, only entries below the count are read.
// Refused operations (bad position, list full, unknown function) leave the
// list untouched and report the reason in o_status.
`timescale 1ns / 1ps

module indexed_list_insert_delete #(
    parameter int DEPTH = ilid_pkg::DEPTH_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ilid_pkg::FUNC_W-1:0]   i_func,
    input  logic [ilid_pkg::POS_W-1:0]    i_position,
    input  logic signed [ilid_pkg::DATA_W-1:0] i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [ilid_pkg::DATA_W-1:0] o_read_value,
    output logic [ilid_pkg::STATUS_W-1:0] o_status,
    output logic [ilid_pkg::ECOUNT_W-1:0] o_entry_count
);
    import ilid_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_read_value;
    logic [STATUS_W-1:0] r_status;
    logic [ECOUNT_W-1:0] r_entry_count;

    logic                accept;
    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       count_x;
    logic [XW-1:0]       ins_pos;
    logic                list_full;
    logic [DATA_W-1:0]   rd_value;
    logic [STATUS_W-1:0] st;
    logic                do_ins;
    logic                do_del;
    logic [CW-1:0]       op_pos;
    t_cell_ctl           cell_ctl;
    logic [DATA_W-1:0]   cell_value [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_x     = XW'(i_position);
    assign count_x   = XW'(r_count);
    assign list_full = (r_count == FULL_COUNT);

    always_comb begin
        rd_value = '0;
        st       = ST_DONE;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        ins_pos  = pos_x;
        case (i_func)
            FUNC_GET: begin
                if (pos_x < count_x) begin
                    rd_value = cell_value[pos_x[AW-1:0]];
                end else begin
                    rd_value = '1;
                    st       = ST_BAD_POS;
                end
            end
            FUNC_INSERT, FUNC_HEAD, FUNC_TAIL: begin
                if (i_func == FUNC_HEAD) begin
                    ins_pos = '0;
                end else if (i_func == FUNC_TAIL) begin
                    ins_pos = count_x;
                end
                // position is checked before fullness
                if (ins_pos > count_x) begin
                    st = ST_BAD_POS;
                end else if (list_full) begin
                    st = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            FUNC_DELETE: begin
                if (pos_x >= count_x) begin
                    st = ST_BAD_POS;
                end else begin
                    do_del = 1'b1;
                end
            end
            default: begin
                st = ST_BAD_POS;
            end
        endcase
    end

    // a valid position never exceeds the count, so it fits the count width
    assign op_pos       = ins_pos[CW-1:0];
    assign cell_ctl.ins = accept && do_ins;
    assign cell_ctl.del = accept && do_del;

    always_comb begin
        n_count = r_count;
        if (cell_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (cell_ctl.del) begin
            n_count = r_count - CW'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;
            if (gi == 0) begin : g_first
                assign left_in = i_item_value;
            end else begin : g_mid_l
                assign left_in = cell_value[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_in = cell_value[gi];
            end else begin : g_mid_r
                assign right_in = cell_value[gi+1];
            end
            ilid_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl),
                .i_pos   (op_pos),
                .i_value (i_item_value),
                .i_left  (left_in),
                .i_right (right_in),
                .o_value (cell_value[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value  <= rd_value;
            r_status      <= st;
            r_entry_count <= ECOUNT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

endmodule

// ===== hw/rtl/ilid_checker.sv =====
// port-level checks for the indexed list block, bound to the top level
`timescale 1ns / 1ps

module ilid_checker #(
    parameter int DEPTH = ilid_pkg::DEPTH_DFLT
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [ilid_pkg::DATA_W-1:0] o_read_value,
    input logic [ilid_pkg::STATUS_W-1:0] o_status,
    input logic [ilid_pkg::ECOUNT_W-1:0] o_entry_count
);
    import ilid_pkg::*;

    localparam logic [ECOUNT_W-1:0] FULL_ECOUNT = ECOUNT_W'(DEPTH);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("result word changed while stalled");

    // reset drops any pending result
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a full refusal only when the count sits at the depth, and reads nothing
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |->
            o_entry_count == FULL_ECOUNT && o_read_value == 0)
        else $error("full status with count below depth");

    // refused position reads back as zero or minus one only
    a_bad_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_BAD_POS |->
            o_read_value == 0 || o_read_value == -1)
        else $error("bad position with unexpected read value");

    // an accepted word is answered in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result after accepted word");

endmodule

bind indexed_list_insert_delete ilid_checker #(.DEPTH(DEPTH)) u_ilid_checker (.*);

// ===== test/tb_indexed_list_insert_delete.sv =====
// scoreboard, stimulus and checks for the indexed list block
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete;

    import ilid_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DFLT;
    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_WORDS = 1300;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        logic signed [DATA_W-1:0] rd;
        logic [STATUS_W-1:0]      st;
        logic [ECOUNT_W-1:0]      cnt;
    } t_list_result;

    typedef enum {PH_FILL, PH_CHURN, PH_DRAIN} t_load_phase;

    // list image kept in step with accepted words
    class list_scoreboard;
        logic signed [DATA_W-1:0] slots [LIST_DEPTH];
        int unsigned fill = 0;
        t_list_result due [$];
        int errors = 0;
        int checked = 0;
        int peak = 0;
        int full_refusals = 0;
        int bad_positions = 0;
        int op_seen [8] = '{default: 0};

        function int unsigned level();
            return fill;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function logic [STATUS_W-1:0] put_at(int unsigned at, logic signed [DATA_W-1:0] v);
            int unsigned i;
            if (at > fill) return ST_BAD_POS;
            if (fill >= LIST_DEPTH) return ST_FULL;
            for (i = fill; i > at; i--) slots[i] = slots[i-1];
            slots[at] = v;
            fill++;
            return ST_DONE;
        endfunction

        function logic [STATUS_W-1:0] take_at(int unsigned at);
            int unsigned i;
            if (at >= fill) return ST_BAD_POS;
            for (i = at; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            return ST_DONE;
        endfunction

        function void note_word(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                logic signed [DATA_W-1:0] v);
            t_list_result r;
            r.rd = '0;
            case (f)
                FUNC_GET: begin
                    if (p < fill) begin
                        r.rd = slots[p];
                        r.st = ST_DONE;
                    end else begin
                        r.rd = -1;
                        r.st = ST_BAD_POS;
                    end
                end
                FUNC_INSERT: r.st = put_at(p, v);
                FUNC_HEAD:   r.st = put_at(0, v);
                FUNC_TAIL:   r.st = put_at(fill, v);
                FUNC_DELETE: r.st = take_at(p);
                default:     r.st = ST_BAD_POS;
            endcase
            r.cnt = ECOUNT_W'(fill);
            op_seen[f]++;
            if (r.st == ST_FULL) full_refusals++;
            if (r.st == ST_BAD_POS) bad_positions++;
            if (fill > peak) peak = fill;
            due.push_back(r);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] rd, logic [STATUS_W-1:0] st,
                                   logic [ECOUNT_W-1:0] cnt);
            t_list_result e;
            checked++;
            if (due.size() == 0) begin
                $error("result with nothing outstanding: read_value %0d status %0d count %0d",
                       rd, st, cnt);
                errors++;
                return;
            end
            e = due.pop_front();
            if (rd !== e.rd) begin
                $error("read_value mismatch: expected %0d, actual %0d", e.rd, rd);
                errors++;
            end
            if (st !== e.st) begin
                $error("status mismatch: expected %0d, actual %0d", e.st, st);
                errors++;
            end
            if (cnt !== e.cnt) begin
                $error("entry_count mismatch: expected %0d, actual %0d", e.cnt, cnt);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [FUNC_W-1:0]          i_func;
    logic [POS_W-1:0]           i_position;
    logic signed [DATA_W-1:0]   i_item_value;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [DATA_W-1:0]   o_read_value;
    logic [STATUS_W-1:0]        o_status;
    logic [ECOUNT_W-1:0]        o_entry_count;

    list_scoreboard sb = new();
    int burst_left = 0;

    indexed_list_insert_delete #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(CLK_PERIOD * 1000000);
        $display("indexed_list_insert_delete verification failed");
        $finish;
    end

    // mostly short idles, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 82) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    // mostly legal positions for the current fill, sometimes anywhere
    function automatic void pick_word(input t_load_phase ph, input int unsigned lvl,
                                      output logic [FUNC_W-1:0] f,
                                      output logic [POS_W-1:0] p,
                                      output logic signed [DATA_W-1:0] v);
        int r;
        int hi;
        r = $urandom_range(0, 99);
        v = pick_value();
        if (r < 8) begin
            f = FUNC_W'($urandom_range(0, 7));
            p = POS_W'($urandom_range(0, 63));
            return;
        end
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                f = (r < 30) ? FUNC_INSERT : (r < 50) ? FUNC_HEAD : (r < 70) ? FUNC_TAIL :
                    (r < 90) ? FUNC_GET : FUNC_DELETE;
            PH_DRAIN:
                f = (r < 55) ? FUNC_DELETE : (r < 80) ? FUNC_GET : (r < 90) ? FUNC_INSERT :
                    (r < 95) ? FUNC_HEAD : FUNC_TAIL;
            default:
                f = (r < 25) ? FUNC_GET : (r < 45) ? FUNC_INSERT : (r < 55) ? FUNC_HEAD :
                    (r < 65) ? FUNC_TAIL : FUNC_DELETE;
        endcase
        if (f == FUNC_INSERT) hi = (lvl > 63) ? 63 : lvl;
        else hi = (lvl == 0) ? 63 : lvl - 1;
        if ($urandom_range(0, 99) < 85) p = POS_W'($urandom_range(0, hi));
        else p = POS_W'($urandom_range(0, 63));
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                             input logic signed [DATA_W-1:0] v);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(30, 80);
            gap = gap_len();
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= f;
        i_position   <= p;
        i_item_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(f, p, v);
    endtask

    // sender stops offering until every result is back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, ready stretches and one long hold-off
    initial begin
        int run_left;
        int stall_left;
        bit held;
        run_left   = 0;
        stall_left = 0;
        held       = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result(o_read_value, o_status, o_entry_count);
            if (!held && sb.checked >= 300) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (run_left > 0) begin
                run_left--;
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                run_left   = ($urandom_range(0, 29) == 0) ? 200 : $urandom_range(0, 24);
                stall_left = gap_len();
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_load_phase ph;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0] p;
        logic signed [DATA_W-1:0] v;
        int n;
        int extra;
        bit fill_next;

        i_in_valid   <= 1'b0;
        i_func       <= FUNC_GET;
        i_position   <= '0;
        i_item_value <= '0;
        do @(posedge i_clk); while (!i_rst_n);

        // empty list, extremes, every function, bad positions and unknown codes
        send_word(FUNC_GET,    6'd0,  $urandom());
        send_word(FUNC_DELETE, 6'd0,  $urandom());
        send_word(FUNC_INSERT, 6'd1,  32'sh12345678);
        send_word(FUNC_DELETE, 6'd63, $urandom());
        send_word(FUNC_GET,    6'd63, $urandom());
        send_word(FUNC_INSERT, 6'd0,  32'sh7fffffff);
        send_word(FUNC_HEAD,   6'd63, 32'sh80000000);
        send_word(FUNC_TAIL,   6'd0,  -1);
        send_word(FUNC_INSERT, 6'd3,  '0);
        send_word(FUNC_INSERT, 6'd1,  32'sh55555555);
        send_word(FUNC_INSERT, 6'd2,  32'shaaaaaaaa);
        send_word(FUNC_INSERT, 6'd7,  $urandom());
        send_word(FUNC_GET,    6'd0,  $urandom());
        send_word(FUNC_GET,    6'd4,  $urandom());
        send_word(FUNC_GET,    6'd5,  $urandom());
        send_word(FUNC_GET,    6'd63, $urandom());
        send_word(FUNC_DELETE, 6'd0,  $urandom());
        send_word(FUNC_DELETE, 6'd3,  $urandom());
        send_word(FUNC_DELETE, 6'd4,  $urandom());
        send_word(3'd5,        6'd63, $urandom());
        send_word(3'd6,        6'd0,  $urandom());
        send_word(3'd7,        6'd42, $urandom());
        send_word(FUNC_GET,    6'd2,  $urandom());

        // fill to the top, churn, drain to empty, churn, and again
        ph        = PH_FILL;
        extra     = 0;
        fill_next = 1'b0;
        n         = 0;
        while (n < RANDOM_WORDS) begin
            pick_word(ph, sb.level(), f, p, v);
            send_word(f, p, v);
            n++;
            case (ph)
                PH_FILL: begin
                    if (sb.level() == LIST_DEPTH || extra > 0) extra++;
                    if (extra >= 8) begin
                        wait_for_drain();
                        ph    = PH_CHURN;
                        extra = $urandom_range(60, 140);
                    end
                end
                PH_DRAIN: begin
                    if (sb.level() == 0 || extra > 0) extra++;
                    if (extra >= 5) begin
                        ph    = PH_CHURN;
                        extra = $urandom_range(60, 140);
                    end
                end
                default: begin
                    extra--;
                    if (extra == 0) begin
                        ph        = fill_next ? PH_FILL : PH_DRAIN;
                        fill_next = !fill_next;
                    end
                end
            endcase
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("run covered %0d words: %0d gets, %0d position inserts, %0d head, %0d tail,",
                 n + 23, sb.op_seen[FUNC_GET], sb.op_seen[FUNC_INSERT],
                 sb.op_seen[FUNC_HEAD], sb.op_seen[FUNC_TAIL]);
        $display("  %0d deletes, %0d unused codes", sb.op_seen[FUNC_DELETE],
                 sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]);
        $display("%0d results checked, %0d full refusals, %0d bad positions, peak fill %0d of %0d",
                 sb.checked, sb.full_refusals, sb.bad_positions, sb.peak, LIST_DEPTH);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("indexed_list_insert_delete verification clean");
        end else begin
            $display("indexed_list_insert_delete verification failed");
        end
        $finish;
    end

endmodule
